[rtl/core/mmcf_pkg.sv]
// ----------------------------------------------------------------------------
// mmcf_pkg
// Shared types and codes for the multicycle MIPS control unit: state codes,
// strobe bit positions, opcodes, funct codes, datapath select codes.
// ----------------------------------------------------------------------------
package mmcf_pkg;

    localparam int INSTR_W = 32;
    localparam int STATE_W = 4;
    localparam int OUT_W   = 64;

    // control states
    localparam logic [STATE_W-1:0] ST_BUFF   = 4'd0;
    localparam logic [STATE_W-1:0] ST_FETCH  = 4'd1;
    localparam logic [STATE_W-1:0] ST_DECODE = 4'd2;
    localparam logic [STATE_W-1:0] ST_LW1    = 4'd3;
    localparam logic [STATE_W-1:0] ST_LW2    = 4'd4;
    localparam logic [STATE_W-1:0] ST_SW     = 4'd5;
    localparam logic [STATE_W-1:0] ST_ALU1   = 4'd6;
    localparam logic [STATE_W-1:0] ST_ALU2   = 4'd7;
    localparam logic [STATE_W-1:0] ST_MULT2  = 4'd8;
    localparam logic [STATE_W-1:0] ST_IMM1   = 4'd9;
    localparam logic [STATE_W-1:0] ST_IMM2   = 4'd10;
    localparam logic [STATE_W-1:0] ST_BR     = 4'd11;
    localparam logic [STATE_W-1:0] ST_JMP    = 4'd12;
    localparam logic [STATE_W-1:0] ST_HALT   = 4'd13;
    localparam logic [STATE_W-1:0] ST_ERR    = 4'd14;

    // strobe bit positions
    localparam int SB_PCCOND = 0;
    localparam int SB_PCWR   = 1;
    localparam int SB_MEMRD  = 2;
    localparam int SB_MEMWR  = 3;
    localparam int SB_REGWR  = 4;
    localparam int SB_LOWR   = 5;
    localparam int SB_IRWR   = 6;
    localparam int SB_RD     = 7;

    // opcodes
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2b;
    localparam logic [5:0] OP_STOP  = 6'h3f;

    // immediate sub-opcodes (low three opcode bits)
    localparam logic [2:0] IMM_ADD = 3'd0;
    localparam logic [2:0] IMM_SLT = 3'd2;
    localparam logic [2:0] IMM_AND = 3'd4;
    localparam logic [2:0] IMM_OR  = 3'd5;
    localparam logic [2:0] IMM_LUI = 3'd7;

    // funct codes
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_SLLV = 6'h04;
    localparam logic [5:0] FN_SRLV = 6'h06;
    localparam logic [5:0] FN_SRAV = 6'h07;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_SLT  = 6'h2A;

    // ALU operations
    localparam logic [4:0] ALU_ADD  = 5'd0;
    localparam logic [4:0] ALU_SUB  = 5'd1;
    localparam logic [4:0] ALU_XOR  = 5'd2;
    localparam logic [4:0] ALU_AND  = 5'd6;
    localparam logic [4:0] ALU_OR   = 5'd14;
    localparam logic [4:0] ALU_MULT = 5'd16;

    // ALU B select
    localparam logic [2:0] BSEL_REG   = 3'd0;
    localparam logic [2:0] BSEL_FOUR  = 3'd1;
    localparam logic [2:0] BSEL_SIMM  = 3'd2;
    localparam logic [2:0] BSEL_SHIMM = 3'd3;
    localparam logic [2:0] BSEL_ZIMM  = 3'd4;

    // PC source
    localparam logic [1:0] PCSRC_ALU = 2'd0;
    localparam logic [1:0] PCSRC_BR  = 2'd1;
    localparam logic [1:0] PCSRC_J   = 2'd2;

    // memory address source
    localparam logic [1:0] ADDR_PC    = 2'd0;
    localparam logic [1:0] ADDR_ALU   = 2'd1;
    localparam logic [1:0] ADDR_OTHER = 2'd2;

    // shift amount source
    localparam logic [1:0] SHSEL_NONE  = 2'd0;
    localparam logic [1:0] SHSEL_REG   = 2'd2;
    localparam logic [1:0] SHSEL_SHAMT = 2'd3;

    // writeback select
    localparam logic [2:0] WB_MEM   = 3'd0;
    localparam logic [2:0] WB_ALU   = 3'd1;
    localparam logic [2:0] WB_LO    = 3'd2;
    localparam logic [2:0] WB_SHIFT = 3'd3;
    localparam logic [2:0] WB_SLT   = 3'd4;
    localparam logic [2:0] WB_LUI   = 3'd5;

    // status
    localparam logic [1:0] STAT_RUN  = 2'd0;
    localparam logic [1:0] STAT_HALT = 2'd1;
    localparam logic [1:0] STAT_ERR  = 2'd2;

    typedef struct packed {
        logic [1:0] status;
        logic       shift_arith;
        logic       shift_right;
        logic [1:0] shift_amount_sel;
        logic [4:0] alu_op;
        logic [1:0] addr_source;
        logic [2:0] alu_b_sel;
        logic       alu_a_sel;
        logic [1:0] pc_source;
        logic [7:0] strobes;
    } t_ctrl;

endpackage

[rtl/core/mmcf_decode.sv]
// ----------------------------------------------------------------------------
// mmcf_decode
// Combinational control decode: datapath controls, next state and the
// writeback select for the current state and latched instruction.
// ----------------------------------------------------------------------------
module mmcf_decode
    import mmcf_pkg::*;
(
    input  logic [STATE_W-1:0] i_state,
    input  logic [INSTR_W-1:0] i_ir,
    output t_ctrl              o_ctrl,
    output logic [STATE_W-1:0] o_next_state,
    output logic [2:0]         o_wbsel
);

    logic [5:0] op;
    logic [5:0] fn;

    assign op = i_ir[31:26];
    assign fn = i_ir[5:0];

    always_comb begin
        o_ctrl       = '0;
        o_wbsel      = WB_MEM;
        o_next_state = ST_FETCH;
        case (i_state)
            ST_FETCH: begin
                o_ctrl.strobes[SB_IRWR] = 1'b1;
                o_ctrl.strobes[SB_PCWR] = 1'b1;
                o_ctrl.alu_b_sel        = BSEL_FOUR;
                o_next_state            = ST_DECODE;
            end
            ST_DECODE: begin
                o_ctrl.alu_b_sel = BSEL_SHIMM;
                if (op == OP_LW)                  o_next_state = ST_LW1;
                else if (op == OP_SW)             o_next_state = ST_SW;
                else if (op == OP_RTYPE)          o_next_state = ST_ALU1;
                else if (op[5:3] == 3'b001)       o_next_state = ST_IMM1;
                else if (op[5:2] == 4'b0001)      o_next_state = ST_BR;
                else if (op == OP_J)              o_next_state = ST_JMP;
                else if (op == OP_STOP)           o_next_state = ST_HALT;
                else                              o_next_state = ST_ERR;
            end
            ST_LW1: begin
                o_ctrl.strobes[SB_MEMRD] = 1'b1;
                o_ctrl.alu_a_sel         = 1'b1;
                o_ctrl.addr_source       = ADDR_ALU;
                o_ctrl.alu_b_sel         = BSEL_SIMM;
                o_next_state             = ST_LW2;
            end
            ST_LW2: begin
                o_ctrl.strobes[SB_MEMRD] = 1'b1;
                o_ctrl.strobes[SB_REGWR] = 1'b1;
            end
            ST_SW: begin
                o_ctrl.strobes[SB_MEMWR] = 1'b1;
                o_ctrl.alu_a_sel         = 1'b1;
                o_ctrl.addr_source       = ADDR_ALU;
                o_ctrl.alu_b_sel         = BSEL_SIMM;
                o_next_state             = ST_BUFF;
            end
            ST_ALU1: begin
                o_ctrl.alu_a_sel = 1'b1;
                o_ctrl.alu_op    = ALU_OR;
                o_wbsel          = WB_ALU;
                o_next_state     = ST_ALU2;
                case (fn)
                    FN_ADD:  o_ctrl.alu_op = ALU_ADD;
                    FN_SUB:  o_ctrl.alu_op = ALU_SUB;
                    FN_AND:  o_ctrl.alu_op = ALU_AND;
                    FN_OR:   o_ctrl.alu_op = ALU_OR;
                    FN_XOR:  o_ctrl.alu_op = ALU_XOR;
                    FN_SLT: begin
                        o_ctrl.alu_op = ALU_SUB;
                        o_wbsel       = WB_SLT;
                    end
                    FN_MULT: begin
                        o_ctrl.alu_op = ALU_MULT;
                        o_next_state  = ST_MULT2;
                    end
                    FN_SLL: begin
                        o_ctrl.shift_amount_sel = SHSEL_SHAMT;
                        o_wbsel                 = WB_SHIFT;
                    end
                    FN_SLLV: begin
                        o_ctrl.shift_amount_sel = SHSEL_REG;
                        o_wbsel                 = WB_SHIFT;
                    end
                    FN_SRL: begin
                        o_ctrl.shift_right      = 1'b1;
                        o_ctrl.shift_amount_sel = SHSEL_SHAMT;
                        o_wbsel                 = WB_SHIFT;
                    end
                    FN_SRLV: begin
                        o_ctrl.shift_right      = 1'b1;
                        o_ctrl.shift_amount_sel = SHSEL_REG;
                        o_wbsel                 = WB_SHIFT;
                    end
                    FN_SRA: begin
                        o_ctrl.shift_right      = 1'b1;
                        o_ctrl.shift_arith      = 1'b1;
                        o_ctrl.shift_amount_sel = SHSEL_SHAMT;
                        o_wbsel                 = WB_SHIFT;
                    end
                    FN_SRAV: begin
                        o_ctrl.shift_right      = 1'b1;
                        o_ctrl.shift_arith      = 1'b1;
                        o_ctrl.shift_amount_sel = SHSEL_REG;
                        o_wbsel                 = WB_SHIFT;
                    end
                    FN_MFLO: o_wbsel = WB_LO;
                    // unknown funct: skip writeback
                    default: o_next_state = ST_BUFF;
                endcase
            end
            ST_ALU2: begin
                o_ctrl.strobes[SB_MEMRD] = 1'b1;
                o_ctrl.strobes[SB_REGWR] = 1'b1;
                o_ctrl.strobes[SB_RD]    = 1'b1;
            end
            ST_MULT2: begin
                o_ctrl.strobes[SB_MEMRD] = 1'b1;
                o_ctrl.strobes[SB_LOWR]  = 1'b1;
                o_ctrl.alu_op            = ALU_MULT;
                o_next_state             = ST_BUFF;
            end
            ST_IMM1: begin
                o_ctrl.alu_a_sel = 1'b1;
                o_ctrl.alu_b_sel = BSEL_SIMM;
                o_wbsel          = WB_ALU;
                o_next_state     = ST_IMM2;
                case (op[2:0])
                    IMM_ADD: o_ctrl.alu_op = ALU_ADD;
                    IMM_SLT: begin
                        o_ctrl.alu_op = ALU_SUB;
                        o_wbsel       = WB_SLT;
                    end
                    IMM_AND: begin
                        o_ctrl.alu_op    = ALU_AND;
                        o_ctrl.alu_b_sel = BSEL_ZIMM;
                    end
                    IMM_OR: begin
                        o_ctrl.alu_op    = ALU_OR;
                        o_ctrl.alu_b_sel = BSEL_ZIMM;
                    end
                    IMM_LUI: begin
                        o_ctrl.alu_op = ALU_OR;
                        o_wbsel       = WB_LUI;
                    end
                    default: begin
                        o_ctrl.alu_op = ALU_OR;
                        o_next_state  = ST_BUFF;
                    end
                endcase
            end
            ST_IMM2: begin
                o_ctrl.strobes[SB_MEMRD] = 1'b1;
                o_ctrl.strobes[SB_REGWR] = 1'b1;
            end
            ST_BR: begin
                o_ctrl.strobes[SB_MEMRD]  = 1'b1;
                o_ctrl.strobes[SB_PCCOND] = 1'b1;
                o_ctrl.alu_a_sel          = 1'b1;
                o_ctrl.addr_source        = ADDR_OTHER;
                o_ctrl.pc_source          = PCSRC_BR;
                o_ctrl.alu_op             = ALU_SUB;
            end
            ST_JMP: begin
                o_ctrl.strobes[SB_MEMRD] = 1'b1;
                o_ctrl.strobes[SB_PCWR]  = 1'b1;
                o_ctrl.addr_source       = ADDR_OTHER;
                o_ctrl.pc_source         = PCSRC_J;
            end
            ST_HALT: begin
                o_ctrl.status = STAT_HALT;
                o_next_state  = ST_HALT;
            end
            ST_ERR: begin
                o_ctrl.status = STAT_ERR;
                o_next_state  = ST_ERR;
            end
            // buffer fetch, and the unused code
            default: begin
                o_ctrl.strobes[SB_MEMRD] = 1'b1;
                o_ctrl.alu_b_sel         = BSEL_FOUR;
            end
        endcase
    end

endmodule

[rtl/core/mmcf_skid.sv]
// ----------------------------------------------------------------------------
// mmcf_skid
// Output register with a skid slot: the upstream side keeps moving while a
// result waits on a stalled downstream.
// ----------------------------------------------------------------------------
module mmcf_skid
    import mmcf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [OUT_W-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_data
);

    logic             r_main_valid;
    logic             r_skid_valid;
    logic [OUT_W-1:0] r_main;
    logic [OUT_W-1:0] r_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || i_ready) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || i_ready) begin
            if (r_skid_valid) r_main <= r_skid;
            else if (i_valid) r_main <= i_data;
        end else if (i_valid && !r_skid_valid) begin
            r_skid <= i_data;
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid slot holds data while output register is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (!r_skid_valid && r_main_valid))
        else $error("skid slot did not drain into output register");

endmodule

[rtl/core/mips_multicycle_control_fsm_top.sv]
// ----------------------------------------------------------------------------
// mips_multicycle_control_fsm_top
// Multicycle MIPS control unit on stream ports: one input transaction is one
// processor clock tick, one output transaction carries the controls of it.
// ----------------------------------------------------------------------------
// Each accepted input transaction advances the control state by one tick and
// yields exactly one output transaction with the controls driven during that
// tick, the instruction register and the registered writeback select. Decode
// is combinational with a registered output, so one transaction can be
// taken every clock while the skid slot is empty; a two-deep output stage
// lets the input side keep going for one extra item while the output stalls.
// The halted and illegal-opcode states hold until reset.
module mips_multicycle_control_fsm_top
    import mmcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] instruction_bus
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] instr_reg, [39:32] strobes, [41:40] pc_source, [42] alu_a_sel,
    // [45:43] alu_b_sel, [47:46] addr_source, [52:48] alu_op,
    // [54:53] shift_amount_sel, [55] shift_right, [56] shift_arith,
    // [59:57] reg_data_sel, [61:60] status, [63:62] zero
    output logic [63:0] m_axis_tdata
);

    logic [STATE_W-1:0] r_state;
    logic [STATE_W-1:0] n_state;
    logic [INSTR_W-1:0] r_ir;
    logic [2:0]         r_wbsel;
    logic [2:0]         n_wbsel;
    t_ctrl              ctrl;
    logic               in_acc;
    logic [OUT_W-1:0]   out_item;

    mmcf_decode u_decode (
        .i_state      (r_state),
        .i_ir         (r_ir),
        .o_ctrl       (ctrl),
        .o_next_state (n_state),
        .o_wbsel      (n_wbsel)
    );

    assign in_acc = s_axis_tvalid && s_axis_tready;

    assign out_item = {2'b00, ctrl.status, r_wbsel, ctrl.shift_arith, ctrl.shift_right,
                       ctrl.shift_amount_sel, ctrl.alu_op, ctrl.addr_source,
                       ctrl.alu_b_sel, ctrl.alu_a_sel, ctrl.pc_source, ctrl.strobes,
                       r_ir};

    // advance one tick per accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_BUFF;
            r_ir    <= '0;
            r_wbsel <= WB_MEM;
        end else if (in_acc) begin
            if (r_state == ST_FETCH) r_ir <= s_axis_tdata;
            r_state <= n_state;
            r_wbsel <= n_wbsel;
        end
    end

    mmcf_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (out_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

    a_halt_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HALT || r_state == ST_ERR) |=> $stable(r_state))
        else $error("halted or error state left without reset");

    a_ir_loads_in_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_acc && r_state == ST_FETCH) |=> $stable(r_ir))
        else $error("instruction register changed outside fetch");

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> ($stable(r_state) && $stable(r_wbsel)))
        else $error("control state moved without an input transaction");

endmodule
